// ----- sv/ulq_pkg.sv -----
// Shared types and constants for the UART line queue.
// No dependencies; imported by uart_line_queue.
package ulq_pkg;

    localparam int LINES    = 64;
    localparam int LINE_LEN = 32;

    localparam int SLOT_W = $clog2(LINES);
    localparam int COL_W  = $clog2(LINE_LEN);
    localparam int DEPTH  = LINES * LINE_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BYTE_W = 8;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    typedef enum logic [2:0] {
        ST_STORED = 3'd0,
        ST_CLOSED = 3'd1,
        ST_FULL   = 3'd2,
        ST_LONG   = 3'd3,
        ST_EMPTY  = 3'd4,
        ST_BYTE   = 3'd5
    } status_t;

    // Line memory address of a column within a slot.
    function automatic logic [ADDR_W-1:0] ulq_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [COL_W-1:0]  col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(slot) * ADDR_W'(LINE_LEN);
        return base + ADDR_W'(col);
    endfunction

endpackage

// ----- sv/ulq_ram.sv -----
// Simple dual-port synchronous RAM, one write and one read port.
// Read data registered, valid in the cycle after the read. No package dependencies.
module ulq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/uart_line_queue.sv -----
// Top level of the UART line queue: slot/column control, pop sequencer, output register.
// Depends on ulq_pkg and ulq_ram.
//
//  port group | dir | tdata            | tuser       | tlast
//  s_*        | in  | [7:0] rx_byte    | [0] req_type| -
//  m_*        | out | [7:0] out_byte   | [2:0] status| last
//
// A byte word gives one result word.
// A pop of a line with n characters gives n+1 words; the line memory read port streams one
// character per cycle while the output register is free to take it.
// A result waiting in the output register holds off new input words and pop progress.
// Reset clears state, slots, columns and output valid; the line memory is not cleared.
module uart_line_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ulq_pkg::BYTE_W-1:0] s_tdata,  // [7:0] rx_byte
    input  logic                      s_tuser,   // [0] req_type
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ulq_pkg::BYTE_W-1:0] m_tdata,  // [7:0] out_byte
    output logic [2:0]                m_tuser,   // [2:0] status
    output logic                      m_tlast
);

    import ulq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_TERM
    } state_t;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  wslot_reg, wslot_next;
    logic [SLOT_W-1:0]  rslot_reg, rslot_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [COL_W-1:0]   pcol_reg, pcol_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;

    logic               out_free;
    logic [SLOT_W-1:0]  wslot_inc, rslot_inc;
    logic               wr_en, rd_en;
    logic [BYTE_W-1:0]  wr_data, rd_data;
    logic [COL_W-1:0]   rd_col;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign wslot_inc = (wslot_reg == SLOT_W'(LINES - 1)) ? '0 : wslot_reg + SLOT_W'(1);
    assign rslot_inc = (rslot_reg == SLOT_W'(LINES - 1)) ? '0 : rslot_reg + SLOT_W'(1);
    assign wr_addr   = ulq_addr(wslot_reg, col_reg);
    assign rd_addr   = ulq_addr(rslot_reg, rd_col);

    always_comb begin
        state_next    = state_reg;
        wslot_next    = wslot_reg;
        rslot_next    = rslot_reg;
        col_next      = col_reg;
        pcol_next     = pcol_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        wr_data       = s_tdata;
        rd_en         = 1'b0;
        rd_col        = pcol_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = CH_NUL;
                    m_last_next  = 1'b1;
                    if (s_tuser == REQ_BYTE) begin
                        if (wslot_inc == rslot_reg) begin
                            m_status_next = ST_FULL;
                        end else if (s_tdata == CH_LF || s_tdata == CH_CR) begin
                            wr_en         = 1'b1;
                            wr_data       = CH_NUL;
                            col_next      = '0;
                            wslot_next    = wslot_inc;
                            m_status_next = ST_CLOSED;
                        end else if (col_reg >= COL_W'(LINE_LEN - 1)) begin
                            m_status_next = ST_LONG;
                        end else begin
                            wr_en         = 1'b1;
                            col_next      = col_reg + COL_W'(1);
                            m_status_next = ST_STORED;
                        end
                    end else if (wslot_reg == rslot_reg) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        // first character read now, result comes from S_POP
                        m_valid_next = 1'b0;
                        rd_en        = 1'b1;
                        rd_col       = '0;
                        pcol_next    = '0;
                        state_next   = S_POP;
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_BYTE;
                    if (rd_data == CH_NUL) begin
                        m_byte_next = CH_NUL;
                        m_last_next = 1'b1;
                        rslot_next  = rslot_inc;
                        state_next  = S_IDLE;
                    end else begin
                        m_byte_next = rd_data;
                        m_last_next = 1'b0;
                        if (pcol_reg == COL_W'(LINE_LEN - 2)) begin
                            state_next = S_TERM;
                        end else begin
                            // fetch next column while this word goes out
                            rd_en     = 1'b1;
                            rd_col    = pcol_reg + COL_W'(1);
                            pcol_next = pcol_reg + COL_W'(1);
                        end
                    end
                end
            end
            S_TERM: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_BYTE;
                    m_byte_next   = CH_NUL;
                    m_last_next   = 1'b1;
                    rslot_next    = rslot_inc;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wslot_reg   <= '0;
            rslot_reg   <= '0;
            col_reg     <= '0;
            pcol_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wslot_reg    <= wslot_next;
            rslot_reg    <= rslot_next;
            col_reg      <= col_next;
            pcol_reg     <= pcol_next;
            m_valid_reg  <= m_valid_next;
            m_status_reg <= m_status_next;
            m_byte_reg   <= m_byte_next;
            m_last_reg   <= m_last_next;
        end
    end

    // Writes happen only in S_IDLE, so a pop read never meets a write to the same entry.
    ulq_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP || state_reg == S_TERM) |-> (rslot_reg != wslot_reg))
        else $error("pop in progress on an empty queue");

    a_wslot_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && wslot_reg != $past(wslot_reg))
            |-> (m_valid_reg && m_status_reg == ST_CLOSED))
        else $error("write slot advanced without a line close");

    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_BYTE && m_tlast) |-> (m_tdata == CH_NUL))
        else $error("line terminator word carries a nonzero byte");

    a_rslot_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && rslot_reg != $past(rslot_reg))
            |-> (m_valid_reg && m_status_reg == ST_BYTE && m_last_reg))
        else $error("read slot advanced without a final pop word");
`endif

endmodule

// ----- test/tb_top.sv -----
// Testbench for uart_line_queue: directed and random byte/pop traffic against a line-queue
// predictor, with random idle on both stream sides. Depends on ulq_pkg and uart_line_queue.
`timescale 1ns / 1ps

module tb_top;
    import ulq_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int MAX_IDLE   = 12;
    localparam int QUIET_MAX  = 1000;
    localparam int DRAIN_CYC  = LINE_LEN + 8;

    typedef struct {
        status_t            status;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } line_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;   // [7:0] rx_byte
    logic              s_tuser;   // [0] req_type
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;   // [7:0] out_byte
    logic [2:0]        m_tuser;   // [2:0] status
    logic              m_tlast;

    // predictor state
    logic [BYTE_W-1:0] line_mem [LINES][LINE_LEN];
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [COL_W-1:0]  col;
    line_result_t      expected_results[$];

    int n_errors;
    bit idle_on;

    uart_line_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic void push_result(input status_t st, input logic [BYTE_W-1:0] d,
                                        input logic l);
        expected_results.push_back('{st, d, l});
    endfunction

    // Line queue behavior for one accepted word.
    function automatic void predict_line_queue(input logic req, input logic [BYTE_W-1:0] b);
        logic [SLOT_W-1:0] nxt;
        nxt = wr_slot + 1'b1;
        if (req == REQ_BYTE) begin
            if (nxt == rd_slot) begin
                push_result(ST_FULL, CH_NUL, 1'b1);
            end else if (b == CH_LF || b == CH_CR) begin
                line_mem[wr_slot][col] = CH_NUL;
                col = '0;
                wr_slot = nxt;
                push_result(ST_CLOSED, CH_NUL, 1'b1);
            end else if (int'(col) >= LINE_LEN - 1) begin
                push_result(ST_LONG, CH_NUL, 1'b1);
            end else begin
                line_mem[wr_slot][col] = b;
                col = col + 1'b1;
                push_result(ST_STORED, CH_NUL, 1'b1);
            end
        end else if (wr_slot == rd_slot) begin
            push_result(ST_EMPTY, CH_NUL, 1'b1);
        end else begin
            // a stored zero ends the line early
            for (int c = 0; c < LINE_LEN - 1; c++) begin
                if (line_mem[rd_slot][c] == CH_NUL) break;
                push_result(ST_BYTE, line_mem[rd_slot][c], 1'b0);
            end
            push_result(ST_BYTE, CH_NUL, 1'b1);
            rd_slot = rd_slot + 1'b1;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] rand_char();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    // Called and returns at a falling edge; leaves tvalid high for a back-to-back word.
    task automatic send_word(input logic req, input logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_line_queue(req, b);
        @(negedge aclk);
    endtask

    task automatic send_line(input int len, input bit use_cr);
        for (int i = 0; i < len; i++) send_word(REQ_BYTE, rand_char());
        send_word(REQ_BYTE, use_cr ? CH_CR : CH_LF);
    endtask

    task automatic test_directed_edges();
        send_word(REQ_POP, 8'hFF);          // pop with nothing queued
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h01);
        send_word(REQ_BYTE, 8'h80);
        send_word(REQ_BYTE, 8'h7F);
        send_word(REQ_BYTE, 8'h55);
        send_word(REQ_BYTE, 8'hAA);
        send_word(REQ_BYTE, CH_LF);
        send_word(REQ_BYTE, CH_NUL);        // stored zero cuts the line on readout
        send_word(REQ_BYTE, 8'h41);
        send_word(REQ_BYTE, CH_CR);
        send_word(REQ_BYTE, CH_CR);         // empty line
        send_word(REQ_POP, 8'h00);
        send_word(REQ_POP, 8'hFF);
        send_word(REQ_POP, 8'h5A);
        send_word(REQ_POP, 8'hA5);          // empty again
        send_word(REQ_BYTE, 8'h20);         // open line, must not be popped
        send_word(REQ_POP, 8'h00);
    endtask

    task automatic test_overlong_line();
        idle_on = 1'b0;
        send_line(LINE_LEN + 2, 1'b0);      // closes the open line plus overlong bytes
        send_word(REQ_POP, rand_char());
        idle_on = 1'b1;
        send_line(LINE_LEN - 1, 1'b1);      // exactly the longest line that fits
        send_word(REQ_POP, rand_char());
    endtask

    task automatic test_queue_full();
        logic [SLOT_W-1:0] n_close;
        logic [SLOT_W-1:0] n_pop;
        n_close = rd_slot - wr_slot - 1'b1;
        for (int i = 0; i < int'(n_close); i++) begin
            send_line(($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0,
                      1'($urandom_range(0, 1)));
        end
        // every word is dropped while full, terminators too
        send_word(REQ_BYTE, CH_CR);
        send_word(REQ_BYTE, CH_LF);
        send_word(REQ_BYTE, rand_char());
        send_word(REQ_BYTE, rand_char());
        n_pop = wr_slot - rd_slot;
        for (int i = 0; i < int'(n_pop); i++) begin
            if (i % 16 == 0) idle_on = ~idle_on;
            send_word(REQ_POP, BYTE_W'($urandom_range(0, 255)));
        end
        idle_on = 1'b1;
        send_word(REQ_POP, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic(input int n_words);
        int pick;
        int len;
        for (int k = 0; k < n_words; ) begin
            if ($urandom_range(0, 3) == 0) idle_on = ~idle_on;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(LINE_LEN - 6, LINE_LEN + 2)
                                                   : $urandom_range(0, 8);
                for (int i = 0; i < len; i++) begin
                    send_word(REQ_BYTE, ($urandom_range(0, 19) == 0) ? CH_NUL : rand_char());
                end
                send_word(REQ_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
                k += len + 1;
            end else if (pick < 9) begin
                send_word(REQ_POP, BYTE_W'($urandom_range(0, 255)));
                k++;
            end else begin
                send_word(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
                k++;
            end
        end
        // drain what is left
        while (wr_slot != rd_slot) send_word(REQ_POP, BYTE_W'($urandom_range(0, 255)));
        idle_on = 1'b1;
    endtask

    // result word checker
    initial begin
        logic [2:0]        got_status;
        logic [BYTE_W-1:0] got_data;
        logic              got_last;
        line_result_t      want;
        int                stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got_status = m_tuser;
            got_data   = m_tdata;
            got_last   = m_tlast;
            // compare at the falling edge so the predictor has run for this edge
            @(negedge aclk);
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word status %0d data %02h last %0b", $time,
                         got_status, got_data, got_last);
            end else begin
                want = expected_results.pop_front();
                if (got_status !== want.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             got_status);
                end
                if (got_data !== want.data) begin
                    n_errors++;
                    $display("%0t: data expected %02h got %02h", $time, want.data, got_data);
                end
                if (got_last !== want.last) begin
                    n_errors++;
                    $display("%0t: last expected %0b got %0b", $time, want.last, got_last);
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < QUIET_MAX) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = REQ_BYTE;
        s_tdata  = '0;
        wr_slot  = '0;
        rd_slot  = '0;
        col      = '0;
        n_errors = 0;
        idle_on  = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_overlong_line();
        test_queue_full();
        test_random_traffic(40);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ulq_pkg.sv
sv/ulq_ram.sv
sv/uart_line_queue.sv
test/tb_top.sv
